// ===== src/cot_pkg.sv =====
// Package for the circle overlap position table: field widths, transfer structs,
// sequencer states and the control group passed from the sequencer to the top level.
// No dependencies.
package cot_pkg;

    // Fixed field widths.
    localparam int ID_W     = 4;
    localparam int POS_W    = 16;
    localparam int RADIUS_W = 15;
    localparam int NOW_W    = 4;
    localparam int TOTAL_W  = 32;

    // Radius sum and its square.
    localparam int RS_W = RADIUS_W + 1;
    localparam int SQ_W = 2 * RS_W;

    // Largest value shown in overlaps_now.
    localparam int NOW_MAX = (1 << NOW_W) - 1;

    // Cycles from a read issue to its hit being counted.
    localparam int CHECK_LAT = 3;
    localparam int DRAIN_W   = $clog2(CHECK_LAT);

    // Parameter defaults.
    localparam int MAX_ROBOTS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;

    typedef struct packed {
        logic [ID_W-1:0]        robot_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [RADIUS_W-1:0]    radius;
    } cot_in_t;

    typedef struct packed {
        logic               overlap_found;
        logic [NOW_W-1:0]   overlaps_now;
        logic [TOTAL_W-1:0] overlap_total;
    } cot_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } cot_state_t;

    // Sequencer events seen by the result logic.
    typedef struct packed {
        logic accept;
        logic finish;
    } cot_ctl_t;

endpackage

// ===== src/cot_entry_mem.sv =====
// Table memory: one entry per robot holding circle centre and radius.
// One write port and one read port with registered read data. Uses cot_pkg.
module cot_entry_mem
    import cot_pkg::*;
#(
    parameter int DEPTH = MAX_ROBOTS_DEF,
    parameter int CW    = COORD_BITS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [CW-1:0] wr_x,
    input  logic signed [CW-1:0] wr_y,
    input  logic [RADIUS_W-1:0] wr_r,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [CW-1:0] rd_x,
    output logic signed [CW-1:0] rd_y,
    output logic [RADIUS_W-1:0] rd_r
);

    localparam int EW = 2 * CW + RADIUS_W;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y, wr_r};
        end
    end

    // Read port with registered read data, available in the cycle after the read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_x = rd_data_reg[EW-1 -: CW];
    assign rd_y = rd_data_reg[RADIUS_W +: CW];
    assign rd_r = rd_data_reg[RADIUS_W-1:0];

endmodule

// ===== src/cot_pair_check.sv =====
// Pipelined overlap test between the current circle and one stored circle per cycle.
// Stages: distance and far test, exact squares, sum and compare. Uses cot_pkg.
module cot_pair_check
    import cot_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 chk,
    input  logic signed [CW-1:0] ent_x,
    input  logic signed [CW-1:0] ent_y,
    input  logic [RADIUS_W-1:0]  ent_r,
    input  logic signed [CW-1:0] cur_x,
    input  logic signed [CW-1:0] cur_y,
    input  logic [RADIUS_W-1:0]  cur_r,
    output logic                 hit
);

    localparam int DW   = CW + 1;
    localparam int CMPW = (DW > RS_W) ? DW : RS_W;

    logic                chk_reg;
    logic                v1_reg;
    logic                near1_reg;
    logic [RS_W-1:0]     dx_reg;
    logic [RS_W-1:0]     dy_reg;
    logic [RS_W-1:0]     rs_reg;
    logic                v2_reg;
    logic                near2_reg;
    logic [SQ_W-1:0]     dx2_reg;
    logic [SQ_W-1:0]     dy2_reg;
    logic [SQ_W-1:0]     rs2_reg;

    logic signed [DW-1:0] dx_s;
    logic signed [DW-1:0] dy_s;
    logic [DW-1:0]        dx_abs;
    logic [DW-1:0]        dy_abs;
    logic [RS_W-1:0]      rs;
    logic                 near;
    logic [SQ_W:0]        dist_sq;

    // Check tag travels alongside the memory read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_reg <= 1'b0;
        end
        else
        begin
            chk_reg <= chk;
        end
    end

    // Stage one: absolute distances, radius sum and the far shortcut.
    always_comb
    begin
        dx_s   = DW'(ent_x) - DW'(cur_x);
        dy_s   = DW'(ent_y) - DW'(cur_y);
        dx_abs = dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
        dy_abs = dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
        rs     = RS_W'(ent_r) + RS_W'(cur_r);
        near   = (CMPW'(dx_abs) <= CMPW'(rs)) && (CMPW'(dy_abs) <= CMPW'(rs));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= chk_reg;
        end
    end

    // Distances fit in the radius sum width whenever the pair is near.
    always_ff @(posedge clk)
    begin
        near1_reg <= near;
        dx_reg    <= RS_W'(dx_abs);
        dy_reg    <= RS_W'(dy_abs);
        rs_reg    <= rs;
    end

    // Stage two: exact squares.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        near2_reg <= near1_reg;
        dx2_reg   <= dx_reg * dx_reg;
        dy2_reg   <= dy_reg * dy_reg;
        rs2_reg   <= rs_reg * rs_reg;
    end

    // Stage three: touch or intersect test.
    assign dist_sq = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign hit     = v2_reg && near2_reg && (dist_sq <= {1'b0, rs2_reg});

endmodule

// ===== src/cot_seq.sv =====
// Sequencer: takes an update, writes its table entry, sweeps the table one read per cycle
// and waits for the check pipeline to drain. Holds the valid marks. Uses cot_pkg.
module cot_seq
    import cot_pkg::*;
#(
    parameter int MAX_ROBOTS = MAX_ROBOTS_DEF,
    parameter int CW         = COORD_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_ROBOTS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cot_in_t              upd,
    input  logic                 upd_valid,
    output logic                 upd_stall,
    input  logic                 out_free,
    output cot_ctl_t             ctl,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output logic signed [CW-1:0] wr_x,
    output logic signed [CW-1:0] wr_y,
    output logic                 rd_en,
    output logic [IDX_W-1:0]     rd_addr,
    output logic                 chk,
    output logic signed [CW-1:0] cur_x,
    output logic signed [CW-1:0] cur_y,
    output logic [RADIUS_W-1:0]  cur_r
);

    cot_state_t             state_reg;
    cot_state_t             state_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [DRAIN_W-1:0]     drain_reg;
    logic [DRAIN_W-1:0]     drain_next;
    logic [MAX_ROBOTS-1:0]  valid_reg;
    logic [IDX_W-1:0]       cur_id_reg;
    logic signed [CW-1:0]   cur_x_reg;
    logic signed [CW-1:0]   cur_y_reg;
    logic [RADIUS_W-1:0]    cur_r_reg;

    logic accept;
    logic in_range;
    logic sweep_last;
    logic drain_last;

    assign in_range   = 32'(upd.robot_id) < MAX_ROBOTS;
    assign sweep_last = idx_reg == IDX_W'(MAX_ROBOTS - 1);
    assign drain_last = drain_reg == DRAIN_W'(CHECK_LAT - 1);
    assign accept     = upd_valid && !upd_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_range ? ST_SWEEP : ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (accept)
                begin
                    state_next = in_range ? ST_SWEEP : ST_DONE;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        upd_stall  = 1'b1;
        ctl.accept = accept;
        ctl.finish = 1'b0;
        rd_en      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                upd_stall = 1'b0;
            end
            ST_SWEEP:
            begin
                rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            ST_DONE:
            begin
                upd_stall  = !out_free;
                ctl.finish = out_free;
            end
            default:
            begin
                upd_stall = 1'b1;
            end
        endcase
    end

    // Sweep and drain counters.
    always_comb
    begin
        idx_next   = (state_reg == ST_SWEEP && !sweep_last) ? idx_reg + 1'b1 : '0;
        drain_next = (state_reg == ST_DRAIN && !drain_last) ? drain_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drain_reg <= drain_next;
        end
    end

    // Entry write happens at the accepting edge, only for an in-range robot_id.
    assign wr_en   = accept && in_range;
    assign wr_addr = IDX_W'(upd.robot_id);
    assign wr_x    = CW'(upd.pos_x);
    assign wr_y    = CW'(upd.pos_y);

    // Valid marks are set on write and only cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Current update held for the whole sweep.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_id_reg <= wr_addr;
            cur_x_reg  <= wr_x;
            cur_y_reg  <= wr_y;
            cur_r_reg  <= upd.radius;
        end
    end

    assign rd_addr = idx_reg;
    assign chk     = (state_reg == ST_SWEEP) && valid_reg[idx_reg] && (idx_reg != cur_id_reg);
    assign cur_x   = cur_x_reg;
    assign cur_y   = cur_y_reg;
    assign cur_r   = cur_r_reg;

    // An update is only taken when no sweep is in flight.
    a_accept_idle : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == ST_IDLE || state_reg == ST_DONE))
        else $error("update taken during a sweep");

    // The table is never written while it is being swept.
    a_no_write_sweep : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP || state_reg == ST_DRAIN) |-> !wr_en)
        else $error("table written during a sweep");

    // Valid marks never clear outside reset.
    a_valid_grow : assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("valid mark lost");

endmodule

// ===== src/circle_overlap_position_table.sv =====
// Top level of the circle overlap position table: sequencer, table memory, pair check,
// overlap count, saturating pair total and result register. Uses cot_pkg and all submodules.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------------
//  upd      | in        | upd_valid/upd_stall | robot_id, pos_x, pos_y, radius
//  res      | out       | res_valid/res_stall | overlap_found, overlaps_now, overlap_total
//
// An update with robot_id below MAX_ROBOTS goes through these steps from its transfer to its
// result: the table read port reads one stored entry per cycle, the three-stage check
// pipeline drains, and the result register is loaded once it is free.
// An update with robot_id outside the table skips the sweep and the drain.
// Reset clears the valid marks and the pair total at once; there is no clearing pass.
// A new update is taken while the previous result waits; an update only finishes once the
// result register is free, so a stalled result holds the block after its sweep.
module circle_overlap_position_table
    import cot_pkg::*;
#(
    parameter int MAX_ROBOTS = MAX_ROBOTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  cot_in_t  upd,
    input  logic     upd_valid,
    output logic     upd_stall,
    output cot_out_t res,
    output logic     res_valid,
    input  logic     res_stall
);

    localparam int IDX_W = $clog2(MAX_ROBOTS);
    localparam int CNT_W = $clog2(MAX_ROBOTS);
    localparam int CW    = COORD_BITS;

    cot_ctl_t               ctl;
    logic                   out_free;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic signed [CW-1:0]   wr_x;
    logic signed [CW-1:0]   wr_y;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic signed [CW-1:0]   rd_x;
    logic signed [CW-1:0]   rd_y;
    logic [RADIUS_W-1:0]    rd_r;
    logic                   chk;
    logic signed [CW-1:0]   cur_x;
    logic signed [CW-1:0]   cur_y;
    logic [RADIUS_W-1:0]    cur_r;
    logic                   hit;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic [TOTAL_W:0]       total_sum;
    cot_out_t               res_reg;
    cot_out_t               res_next;
    logic                   res_valid_reg;

    assign out_free = !res_valid_reg || !res_stall;

    cot_seq #(
        .MAX_ROBOTS (MAX_ROBOTS),
        .CW         (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .upd_valid (upd_valid),
        .upd_stall (upd_stall),
        .out_free  (out_free),
        .ctl       (ctl),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_x      (wr_x),
        .wr_y      (wr_y),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .chk       (chk),
        .cur_x     (cur_x),
        .cur_y     (cur_y),
        .cur_r     (cur_r)
    );

    cot_entry_mem #(
        .DEPTH (MAX_ROBOTS),
        .CW    (CW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_x    (wr_x),
        .wr_y    (wr_y),
        .wr_r    (upd.radius),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y),
        .rd_r    (rd_r)
    );

    cot_pair_check #(
        .CW (CW)
    ) u_check (
        .clk   (clk),
        .rst_n (rst_n),
        .chk   (chk),
        .ent_x (rd_x),
        .ent_y (rd_y),
        .ent_r (rd_r),
        .cur_x (cur_x),
        .cur_y (cur_y),
        .cur_r (cur_r),
        .hit   (hit)
    );

    // Overlap count for the update in progress.
    always_comb
    begin
        if (ctl.accept)
        begin
            count_next = '0;
        end
        else if (hit)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Saturating pair total and the result fields.
    always_comb
    begin
        total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(count_reg);
        total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        res_next.overlap_found = count_reg != '0;
        res_next.overlaps_now  = (32'(count_reg) > NOW_MAX) ? NOW_W'(NOW_MAX)
                                                             : NOW_W'(count_reg);
        res_next.overlap_total = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctl.finish)
            begin
                total_reg     <= total_next;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result register is loaded only when free.
    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // The count can never exceed the number of other entries.
    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_ROBOTS - 1)
        else $error("overlap count out of range");

    // The pair total never decreases.
    a_total_mono : assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg >= $past(total_reg)))
        else $error("pair total decreased");

    // The flag agrees with the count in every result.
    a_flag_count : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.overlap_found == (res_reg.overlaps_now != '0)))
        else $error("overlap flag disagrees with count");

    // No check result arrives while a new update is being taken.
    a_hit_window : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |-> !hit)
        else $error("check result outside a sweep");

endmodule
